// ----- design/glyph_row_blitter_assert.svh -----
// Concurrent assertion helpers, clocked on clk_i and held off while rst_ni is low.
`ifndef GLYPH_ROW_BLITTER_ASSERT_SVH
`define GLYPH_ROW_BLITTER_ASSERT_SVH

// Same-cycle implication.
`define GRB_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication.
`define GRB_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- design/grb_pkg.sv -----
`timescale 1ns / 1ps
package grb_pkg;

  localparam int GlyphW = 8;
  localparam int GlyphH = 16;
  localparam int GlyphCount = 64;
  localparam int GlyphIdxW = $clog2(GlyphCount);
  localparam int RowIdxW = $clog2(GlyphH);
  localparam logic [2:0] MaxScale = 3'd4;
  localparam logic [7:0] CodeFirst = 8'h20;
  localparam logic [7:0] CodeLast = 8'h5F;

  typedef struct packed {
    logic [GlyphIdxW-1:0] glyph;
    logic [RowIdxW-1:0]   row;
  } font_addr_t;

endpackage

// ----- design/glyph_row_blitter.sv -----
`timescale 1ns / 1ps
// Latency: a screen row issued to the font ROM read passes the ROM stage, then the output word, as a span.
// Throughput: a command issues 16 * scale_y rows (16 plain, up to 64 scaled), one per cycle while
// the output is not stalled, paced by the single font ROM read port; rows outside the frame are
// issued but emit nothing. The next command is taken once the last row has left the ROM stage.
// Reset (rst_ni low, asynchronous) clears the busy flag and all stage valid flags.
module glyph_row_blitter
  import grb_pkg::*;
#(
  parameter int FRAME_WIDTH  = 320,
  parameter int FRAME_HEIGHT = 240
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               action_i,
  input  logic [7:0]         char_code_i,
  input  logic signed [11:0] pos_x_i,
  input  logic signed [11:0] pos_y_i,
  input  logic [15:0]        fg_color_i,
  input  logic [15:0]        bg_color_i,
  input  logic               transparent_i,
  input  logic [2:0]         scale_x_i,
  input  logic [2:0]         scale_y_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [9:0]         row_y_o,
  output logic signed [11:0] span_x_o,
  output logic [31:0]        write_mask_o,
  output logic [31:0]        fg_mask_o,
  output logic [15:0]        fg_out_o,
  output logic [15:0]        bg_out_o,
  output logic               last_o
);

  localparam logic signed [13:0] FrameW = 14'(FRAME_WIDTH);
  localparam logic signed [13:0] FrameH = 14'(FRAME_HEIGHT);

  // latched command
  logic [GlyphIdxW-1:0] glyph_q;
  logic                 opaque_q;
  logic [11:0]          px_q;
  logic [15:0]          fg_q;
  logic [15:0]          bg_q;
  logic [1:0]           sxm1_q;
  logic [1:0]           sym1_q;
  logic signed [13:0]   last_y_q;
  logic [31:0]          inframe_q;

  // issue counters
  logic                 busy_q;
  logic [RowIdxW-1:0]   row_q;
  logic [1:0]           dy_q;
  logic signed [13:0]   fy_q;

  // ROM stage
  logic                 s1_valid_q;
  logic                 s1_last_q;
  logic [9:0]           s1_fy_q;
  logic [GlyphW-1:0]    rom_data;

  // output word
  logic                 out_valid_q;
  logic [9:0]           row_y_q;
  logic [11:0]          span_x_q;
  logic [31:0]          wm_q;
  logic [31:0]          fgm_q;
  logic [15:0]          fg_out_q;
  logic [15:0]          bg_out_q;
  logic                 last_q;

  logic                 adv;
  logic                 accept;
  logic                 issue;
  logic                 row_end;
  logic                 cmd_end;
  logic                 in_frame;
  logic [1:0]           sxm1_d;
  logic [1:0]           sym1_d;
  logic signed [13:0]   py_ext;
  logic signed [13:0]   span_end;
  logic [7:0]           code_off;
  logic [31:0]          inframe_d;
  logic [31:0]          expanded;
  logic [31:0]          fgm;
  font_addr_t           rom_addr;

  function automatic logic [1:0] clamp_m1(input logic [2:0] s);
    logic [2:0] c;
    c = s;
    if (c == 3'd0) c = 3'd1;
    if (c > MaxScale) c = MaxScale;
    return 2'(c - 3'd1);
  endfunction

  // repeat each glyph pixel (sx_m1 + 1) times, leftmost pixel at bit 0
  function automatic logic [31:0] expand(input logic [GlyphW-1:0] bits,
                                         input logic [1:0] sx_m1);
    logic [31:0] r;
    int          col;
    r = '0;
    for (int j = 0; j < 32; j++) begin
      unique case (sx_m1)
        2'd0: col = j;
        2'd1: col = j / 2;
        2'd2: col = j / 3;
        default: col = j / 4;
      endcase
      if (col < GlyphW) r[j] = bits[GlyphW-1-col];
    end
    return r;
  endfunction

  assign adv        = !out_valid_q || out_ready_i;
  assign in_ready_o = !busy_q && !s1_valid_q;
  assign accept     = in_valid_i && in_ready_o;
  assign issue      = busy_q && adv;
  assign row_end    = dy_q == sym1_q;
  assign cmd_end    = row_end && (row_q == RowIdxW'(GlyphH - 1));
  assign in_frame   = (fy_q >= 14'sd0) && (fy_q < FrameH);

  always_comb begin
    sxm1_d   = action_i ? clamp_m1(scale_x_i) : 2'd0;
    sym1_d   = action_i ? clamp_m1(scale_y_i) : 2'd0;
    py_ext   = 14'(pos_y_i);
    span_end = py_ext + $signed({8'd0, sym1_d, 4'b1111});
    code_off = char_code_i - CodeFirst;
    for (int j = 0; j < 32; j++) begin
      logic signed [13:0] fx;
      fx = 14'(pos_x_i) + 14'(j);
      inframe_d[j] = (j < GlyphW * (int'(sxm1_d) + 1)) && (fx >= 14'sd0) && (fx < FrameW);
    end
  end

  assign rom_addr.glyph = glyph_q;
  assign rom_addr.row   = row_q;

  grb_font_rom u_font_rom (
    .clk_i  (clk_i),
    .en_i   (issue),
    .addr_i (rom_addr),
    .data_o (rom_data)
  );

  assign expanded = expand(rom_data, sxm1_q);
  assign fgm      = expanded & inframe_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      row_q       <= '0;
      dy_q        <= '0;
      fy_q        <= '0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        busy_q <= 1'b1;
        row_q  <= '0;
        dy_q   <= '0;
        fy_q   <= py_ext;
      end else if (issue) begin
        if (cmd_end) busy_q <= 1'b0;
        if (row_end) begin
          dy_q  <= '0;
          row_q <= row_q + 1'b1;
        end else begin
          dy_q <= dy_q + 1'b1;
        end
        fy_q <= fy_q + 14'sd1;
      end
      if (adv) begin
        // drop rows outside the frame here
        s1_valid_q  <= issue && in_frame;
        out_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      glyph_q   <= (char_code_i >= CodeFirst && char_code_i <= CodeLast) ?
                   code_off[GlyphIdxW-1:0] : '0;
      opaque_q  <= !action_i && !transparent_i;
      px_q      <= pos_x_i;
      fg_q      <= fg_color_i;
      bg_q      <= bg_color_i;
      sxm1_q    <= sxm1_d;
      sym1_q    <= sym1_d;
      last_y_q  <= (span_end < FrameH - 14'sd1) ? span_end : FrameH - 14'sd1;
      inframe_q <= inframe_d;
    end
    if (issue) begin
      s1_last_q <= fy_q == last_y_q;
      s1_fy_q   <= fy_q[9:0];
    end
    if (adv && s1_valid_q) begin
      row_y_q  <= s1_fy_q;
      span_x_q <= px_q;
      wm_q     <= opaque_q ? inframe_q : fgm;
      fgm_q    <= fgm;
      fg_out_q <= fg_q;
      bg_out_q <= opaque_q ? bg_q : 16'd0;
      last_q   <= s1_last_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign row_y_o      = row_y_q;
  assign span_x_o     = span_x_q;
  assign write_mask_o = wm_q;
  assign fg_mask_o    = fgm_q;
  assign fg_out_o     = fg_out_q;
  assign bg_out_o     = bg_out_q;
  assign last_o       = last_q;

`include "glyph_row_blitter_assert.svh"

  `GRB_ASSERT_IMPL(a_fg_in_write, out_valid_o, (fg_mask_o & ~write_mask_o) == 32'd0)
  `GRB_ASSERT_IMPL(a_row_in_frame, out_valid_o, 11'(row_y_o) < 11'(FRAME_HEIGHT))
  `GRB_ASSERT_NEXT(a_issue_holds, busy_q && !adv, busy_q && $stable(fy_q) && $stable(row_q))

endmodule

// ----- design/grb_font_rom.sv -----
`timescale 1ns / 1ps
module grb_font_rom
  import grb_pkg::*;
(
  input  logic             clk_i,
  input  logic             en_i,
  input  font_addr_t       addr_i,
  output logic [GlyphW-1:0] data_o
);

  // One glyph per entry, row 0 in the top byte, MSB is the leftmost pixel.
  localparam logic [GlyphW*GlyphH-1:0] FontRom [GlyphCount] = '{
    128'h0,
    128'h00001818181818180018000000000000,
    128'h00666666000000000000000000000000,
    128'h0,
    128'h0,
    128'h0,
    128'h0,
    128'h00001818180000000000000000000000,
    128'h0,
    128'h0,
    128'h0,
    128'h0000000018187E181800000000000000,
    128'h00000000000000000018183000000000,
    128'h0000000000007E000000000000000000,
    128'h00000000000000000018180000000000,
    128'h000006060C0C18183030606000000000,
    128'h00003C66666E7666663C000000000000,
    128'h0000183818181818187E000000000000,
    128'h00003C66060C1830607E000000000000,
    128'h00003C66061C0606663C000000000000,
    128'h00000C1C3C6C7E0C0C0C000000000000,
    128'h00007E60607C0606663C000000000000,
    128'h00003C66607C6666663C000000000000,
    128'h00007E060C1830303030000000000000,
    128'h00003C66663C6666663C000000000000,
    128'h00003C6666663E06663C000000000000,
    128'h00000018180000181800000000000000,
    128'h0,
    128'h0,
    128'h000000007E00007E0000000000000000,
    128'h0,
    128'h00003C66060C18001800000000000000,
    128'h0,
    128'h0000183C66667E666666000000000000,
    128'h00007C66667C6666667C000000000000,
    128'h00003C6660606060663C000000000000,
    128'h0000786C666666666C78000000000000,
    128'h00007E60607C6060607E000000000000,
    128'h00007E60607C60606060000000000000,
    128'h00003C6660606E66663C000000000000,
    128'h00006666667E66666666000000000000,
    128'h00007E1818181818187E000000000000,
    128'h0000060606060666663C000000000000,
    128'h0000666C7870786C6666000000000000,
    128'h0000606060606060607E000000000000,
    128'h000063777F6B63636363000000000000,
    128'h000066767E6E66666666000000000000,
    128'h00003C6666666666663C000000000000,
    128'h00007C66667C60606060000000000000,
    128'h00003C666666666E3C06000000000000,
    128'h00007C66667C786C6666000000000000,
    128'h00003C66603C0606663C000000000000,
    128'h00007E18181818181818000000000000,
    128'h0000666666666666663C000000000000,
    128'h000066666666663C3C18000000000000,
    128'h00006363636B7F776363000000000000,
    128'h000066663C18183C6666000000000000,
    128'h00006666663C18181818000000000000,
    128'h00007E060C183060607E000000000000,
    128'h0,
    128'h00006060303018180C0C060600000000,
    128'h0,
    128'h0,
    128'h0000000000000000000000007E000000
  };

  logic [GlyphW-1:0] data_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= FontRom[addr_i.glyph][{~addr_i.row, 3'b000} +: GlyphW];
    end
  end

  assign data_o = data_q;

endmodule

// ----- test/tb_glyph_row_blitter.sv -----
`timescale 1ns / 1ps

localparam int FrameW = 320;
localparam int FrameH = 240;

typedef struct packed {
  logic        action;
  logic [7:0]  char_code;
  logic [11:0] pos_x;
  logic [11:0] pos_y;
  logic [15:0] fg_color;
  logic [15:0] bg_color;
  logic        transparent;
  logic [2:0]  scale_x;
  logic [2:0]  scale_y;
} glyph_cmd_t;

typedef struct packed {
  logic [9:0]  row_y;
  logic [11:0] span_x;
  logic [31:0] write_mask;
  logic [31:0] fg_mask;
  logic [15:0] fg_out;
  logic [15:0] bg_out;
  logic        last;
} glyph_span_t;

class glyph_span_board;
  glyph_span_t due_spans[$];
  int          errors = 0;

  task report(string msg);
    $display("MISMATCH: %s", msg);
    errors++;
  endtask

  function int pending();
    return due_spans.size();
  endfunction

  // 8x16 font, row 0 in the top byte, MSB of a row is the leftmost pixel
  function logic [127:0] font_rows(int g);
    case (g)
      1:  return 128'h0000_1818_1818_1818_0018_0000_0000_0000;
      2:  return 128'h0066_6666_0000_0000_0000_0000_0000_0000;
      7:  return 128'h0000_1818_1800_0000_0000_0000_0000_0000;
      11: return 128'h0000_0000_1818_7E18_1800_0000_0000_0000;
      12: return 128'h0000_0000_0000_0000_0018_1830_0000_0000;
      13: return 128'h0000_0000_0000_7E00_0000_0000_0000_0000;
      14: return 128'h0000_0000_0000_0000_0018_1800_0000_0000;
      15: return 128'h0000_0606_0C0C_1818_3030_6060_0000_0000;
      16: return 128'h0000_3C66_666E_7666_663C_0000_0000_0000;
      17: return 128'h0000_1838_1818_1818_187E_0000_0000_0000;
      18: return 128'h0000_3C66_060C_1830_607E_0000_0000_0000;
      19: return 128'h0000_3C66_061C_0606_663C_0000_0000_0000;
      20: return 128'h0000_0C1C_3C6C_7E0C_0C0C_0000_0000_0000;
      21: return 128'h0000_7E60_607C_0606_663C_0000_0000_0000;
      22: return 128'h0000_3C66_607C_6666_663C_0000_0000_0000;
      23: return 128'h0000_7E06_0C18_3030_3030_0000_0000_0000;
      24: return 128'h0000_3C66_663C_6666_663C_0000_0000_0000;
      25: return 128'h0000_3C66_6666_3E06_663C_0000_0000_0000;
      26: return 128'h0000_0018_1800_0018_1800_0000_0000_0000;
      29: return 128'h0000_0000_7E00_007E_0000_0000_0000_0000;
      31: return 128'h0000_3C66_060C_1800_1800_0000_0000_0000;
      33: return 128'h0000_183C_6666_7E66_6666_0000_0000_0000;
      34: return 128'h0000_7C66_667C_6666_667C_0000_0000_0000;
      35: return 128'h0000_3C66_6060_6060_663C_0000_0000_0000;
      36: return 128'h0000_786C_6666_6666_6C78_0000_0000_0000;
      37: return 128'h0000_7E60_607C_6060_607E_0000_0000_0000;
      38: return 128'h0000_7E60_607C_6060_6060_0000_0000_0000;
      39: return 128'h0000_3C66_6060_6E66_663C_0000_0000_0000;
      40: return 128'h0000_6666_667E_6666_6666_0000_0000_0000;
      41: return 128'h0000_7E18_1818_1818_187E_0000_0000_0000;
      42: return 128'h0000_0606_0606_0666_663C_0000_0000_0000;
      43: return 128'h0000_666C_7870_786C_6666_0000_0000_0000;
      44: return 128'h0000_6060_6060_6060_607E_0000_0000_0000;
      45: return 128'h0000_6377_7F6B_6363_6363_0000_0000_0000;
      46: return 128'h0000_6676_7E6E_6666_6666_0000_0000_0000;
      47: return 128'h0000_3C66_6666_6666_663C_0000_0000_0000;
      48: return 128'h0000_7C66_667C_6060_6060_0000_0000_0000;
      49: return 128'h0000_3C66_6666_666E_3C06_0000_0000_0000;
      50: return 128'h0000_7C66_667C_786C_6666_0000_0000_0000;
      51: return 128'h0000_3C66_603C_0606_663C_0000_0000_0000;
      52: return 128'h0000_7E18_1818_1818_1818_0000_0000_0000;
      53: return 128'h0000_6666_6666_6666_663C_0000_0000_0000;
      54: return 128'h0000_6666_6666_663C_3C18_0000_0000_0000;
      55: return 128'h0000_6363_636B_7F77_6363_0000_0000_0000;
      56: return 128'h0000_6666_3C18_183C_6666_0000_0000_0000;
      57: return 128'h0000_6666_663C_1818_1818_0000_0000_0000;
      58: return 128'h0000_7E06_0C18_3060_607E_0000_0000_0000;
      60: return 128'h0000_6060_3030_1818_0C0C_0606_0000_0000;
      63: return 128'h0000_0000_0000_0000_0000_0000_7E00_0000;
      default: return '0;
    endcase
  endfunction

  function int eff_scale(logic [2:0] v);
    if (v == 3'd0) return 1;
    if (v > grb_pkg::MaxScale) return int'(grb_pkg::MaxScale);
    return int'(v);
  endfunction

  // Queue every span one accepted command produces, top row first.
  function void render_spans(glyph_cmd_t c);
    int          sx, sy, px, py, width, n, fy, g;
    logic [127:0] rows;
    logic [7:0]  bits;
    logic [31:0] inframe, expanded;
    glyph_span_t s;
    sx = c.action ? eff_scale(c.scale_x) : 1;
    sy = c.action ? eff_scale(c.scale_y) : 1;
    px = int'($signed(c.pos_x));
    py = int'($signed(c.pos_y));
    width = 8 * sx;
    g = (c.char_code >= grb_pkg::CodeFirst && c.char_code <= grb_pkg::CodeLast) ?
        int'(c.char_code - grb_pkg::CodeFirst) : 0;
    rows = font_rows(g);
    inframe = '0;
    for (int j = 0; j < width; j++)
      if (px + j >= 0 && px + j < FrameW) inframe[j] = 1'b1;
    n = 0;
    for (int r = 0; r < 16; r++) begin
      bits = rows[127 - 8 * r -: 8];
      expanded = '0;
      for (int j = 0; j < width; j++)
        if (bits[7 - j / sx]) expanded[j] = 1'b1;
      for (int d = 0; d < sy; d++) begin
        fy = py + r * sy + d;
        if (fy >= 0 && fy < FrameH) begin
          s.row_y      = 10'(fy);
          s.span_x     = c.pos_x;
          s.fg_mask    = expanded & inframe;
          s.write_mask = (c.action || c.transparent) ? s.fg_mask : inframe;
          s.fg_out     = c.fg_color;
          s.bg_out     = (c.action || c.transparent) ? 16'h0 : c.bg_color;
          s.last       = 1'b0;
          due_spans.push_back(s);
          n++;
        end
      end
    end
    if (n > 0) due_spans[$].last = 1'b1;
  endfunction

  function string fmt_span(glyph_span_t s);
    return $sformatf("row %0d x %0d wm %h fm %h fg %h bg %h last %b", s.row_y,
                     $signed(s.span_x), s.write_mask, s.fg_mask, s.fg_out, s.bg_out, s.last);
  endfunction

  task check_span(glyph_span_t got);
    glyph_span_t want;
    if (due_spans.size() == 0) begin
      report({"unexpected span: ", fmt_span(got)});
      return;
    end
    want = due_spans.pop_front();
    if (got !== want) report({"got ", fmt_span(got), " want ", fmt_span(want)});
  endtask
endclass

module tb_glyph_row_blitter;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid;
  logic        in_ready;
  logic        action;
  logic [7:0]  char_code;
  logic [11:0] pos_x;
  logic [11:0] pos_y;
  logic [15:0] fg_color;
  logic [15:0] bg_color;
  logic        transparent;
  logic [2:0]  scale_x;
  logic [2:0]  scale_y;
  logic        out_valid;
  logic        out_rdy = 1'b0;
  logic [9:0]  row_y;
  logic [11:0] span_x;
  logic [31:0] write_mask;
  logic [31:0] fg_mask;
  logic [15:0] fg_out;
  logic [15:0] bg_out;
  logic        last;

  glyph_span_board board = new();
  bit idle_en = 1'b1;
  int stall_left = 0;

  glyph_row_blitter #(
    .FRAME_WIDTH (FrameW),
    .FRAME_HEIGHT(FrameH)
  ) dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready),
    .action_i     (action),
    .char_code_i  (char_code),
    .pos_x_i      (pos_x),
    .pos_y_i      (pos_y),
    .fg_color_i   (fg_color),
    .bg_color_i   (bg_color),
    .transparent_i(transparent),
    .scale_x_i    (scale_x),
    .scale_y_i    (scale_y),
    .out_valid_o  (out_valid),
    .out_ready_i  (out_rdy),
    .row_y_o      (row_y),
    .span_x_o     (span_x),
    .write_mask_o (write_mask),
    .fg_mask_o    (fg_mask),
    .fg_out_o     (fg_out),
    .bg_out_o     (bg_out),
    .last_o       (last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Span sink: check each accepted word, then stall in random bursts.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_rdy)
        board.check_span('{row_y, span_x, write_mask, fg_mask, fg_out, bg_out, last});
      if (stall_left > 0) begin
        stall_left--;
        out_rdy <= (stall_left == 0);
      end else if (idle_en && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 16);
        out_rdy <= 1'b0;
      end else begin
        out_rdy <= 1'b1;
      end
    end
  end

  function automatic glyph_cmd_t mk(int act, int code, int x, int y, int fg, int bg,
                                    int tr, int sx, int sy);
    glyph_cmd_t c;
    c.action      = 1'(act);
    c.char_code   = 8'(code);
    c.pos_x       = 12'(x);
    c.pos_y       = 12'(y);
    c.fg_color    = 16'(fg);
    c.bg_color    = 16'(bg);
    c.transparent = 1'(tr);
    c.scale_x     = 3'(sx);
    c.scale_y     = 3'(sy);
    return c;
  endfunction

  function automatic glyph_cmd_t rand_cmd();
    glyph_cmd_t c;
    c.action      = 1'($urandom_range(0, 1));
    c.char_code   = ($urandom_range(0, 4) == 0) ? 8'($urandom) : 8'($urandom_range(32, 95));
    if ($urandom_range(0, 7) == 0) begin
      c.pos_x = 12'($urandom);
      c.pos_y = 12'($urandom);
    end else begin
      // keep most glyphs on or near the frame so rows and clipping get exercised
      c.pos_x = 12'($urandom_range(0, 420) - 50);
      c.pos_y = 12'($urandom_range(0, 360) - 80);
    end
    c.fg_color    = 16'($urandom);
    c.bg_color    = 16'($urandom);
    c.transparent = 1'($urandom_range(0, 1));
    c.scale_x     = 3'($urandom);
    c.scale_y     = 3'($urandom);
    return c;
  endfunction

  task automatic send_cmd(glyph_cmd_t c);
    in_valid    <= 1'b1;
    action      <= c.action;
    char_code   <= c.char_code;
    pos_x       <= c.pos_x;
    pos_y       <= c.pos_y;
    fg_color    <= c.fg_color;
    bg_color    <= c.bg_color;
    transparent <= c.transparent;
    scale_x     <= c.scale_x;
    scale_y     <= c.scale_y;
    do @(posedge clk); while (!in_ready);
    board.render_spans(c);
    if (idle_en && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
  endtask

  task automatic drain_spans();
    in_valid <= 1'b0;
    do @(posedge clk); while (board.pending() != 0);
  endtask

  initial begin
    in_valid    = 1'b0;
    action      = 1'b0;
    char_code   = '0;
    pos_x       = '0;
    pos_y       = '0;
    fg_color    = '0;
    bg_color    = '0;
    transparent = 1'b0;
    scale_x     = '0;
    scale_y     = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    send_cmd(mk(0, 8'h41, 0, 0, 16'hFFFF, 16'h0000, 0, 1, 1));
    send_cmd(mk(0, 8'h4D, 312, 224, 16'h07E0, 16'hF800, 1, 7, 7));
    send_cmd(mk(0, 8'h00, 100, 100, 16'hFFFF, 16'hFFFF, 0, 0, 0));
    send_cmd(mk(0, 8'hFF, -4, 50, 16'h1234, 16'h5678, 0, 1, 1));
    send_cmd(mk(0, 8'h5F, 316, 10, 16'hABCD, 16'h0F0F, 0, 2, 3));
    send_cmd(mk(0, 8'h20, 40, 40, 16'h0001, 16'h8000, 0, 1, 1));
    send_cmd(mk(0, 8'h60, 40, 60, 16'h1111, 16'h2222, 0, 1, 1));
    send_cmd(mk(0, 8'h1F, 40, 80, 16'h3333, 16'h4444, 1, 1, 1));
    send_cmd(mk(1, 8'h57, 0, 0, 16'hFFFF, 16'hFFFF, 0, 4, 4));
    send_cmd(mk(1, 8'h38, 300, 200, 16'hF81F, 16'h07FF, 1, 7, 7));
    send_cmd(mk(1, 8'h30, 10, 10, 16'h5555, 16'hAAAA, 0, 0, 0));
    send_cmd(mk(1, 8'h2F, 150, -3, 16'h00FF, 16'hFF00, 0, 5, 1));
    send_cmd(mk(0, 8'h5A, 64, 64, 16'h0F0F, 16'hF0F0, 0, 7, 0));
    send_cmd(mk(0, 8'h41, 0, -2048, 16'hFFFF, 16'hFFFF, 0, 1, 1));
    send_cmd(mk(1, 8'h41, 0, 2047, 16'hFFFF, 16'hFFFF, 0, 4, 4));
    send_cmd(mk(0, 8'h48, -2048, 0, 16'h1357, 16'h2468, 0, 1, 1));
    send_cmd(mk(0, 8'h48, 2047, 100, 16'h1357, 16'h2468, 0, 1, 1));
    send_cmd(mk(0, 8'h42, 20, -8, 16'hCAFE, 16'hBEEF, 0, 1, 1));
    send_cmd(mk(0, 8'h43, 20, 232, 16'hCAFE, 16'hBEEF, 1, 1, 1));
    send_cmd(mk(1, 8'h51, 50, -30, 16'h7777, 16'h8888, 0, 2, 4));
    send_cmd(mk(1, 8'h3F, -10, 120, 16'h9999, 16'h6666, 1, 4, 3));
    send_cmd(mk(1, 8'h5C, 318, 100, 16'hAAAA, 16'h5555, 0, 3, 2));
    send_cmd(mk(1, 8'h21, 100, 239, 16'h0000, 16'hFFFF, 0, 1, 1));
    send_cmd(mk(0, 8'h24, -7, -15, 16'h0000, 16'hFFFF, 0, 1, 1));
    send_cmd(mk(1, 8'h3A, 313, 0, 16'h0000, 16'hFFFF, 1, 2, 2));
    drain_spans();

    for (int i = 0; i < 155; i++) begin
      if (i == 80) drain_spans();
      if (i == 125) idle_en = 1'b0;
      send_cmd(rand_cmd());
    end
    drain_spans();
    // a trailing command may still be walking off-frame rows
    repeat (100) @(posedge clk);

    if (board.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
